>>> rtl/mkde_pkg.sv
// Package: shared constants, types and the per-key history function.
`timescale 1ns / 1ps
`default_nettype none
package mkde_pkg;

  localparam int NUM_KEYS    = 16;
  localparam int SLOTS       = 16;
  localparam int IDX_W       = 4;
  localparam int CODE_W      = 2;
  localparam int HIST_W      = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_ENABLE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_POLARITY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EVENT_ENABLE   = 2'd2;

  // Event codes
  localparam logic [CODE_W-1:0] EV_UP      = 2'd0;
  localparam logic [CODE_W-1:0] EV_PUSH    = 2'd1;
  localparam logic [CODE_W-1:0] EV_RELEASE = 2'd2;
  localparam logic [CODE_W-1:0] EV_DOWN    = 2'd3;

  // History patterns
  localparam logic [HIST_W-1:0] H_UP      = 3'h0;
  localparam logic [HIST_W-1:0] H_GLITCH0 = 3'h2;
  localparam logic [HIST_W-1:0] H_PUSH    = 3'h3;
  localparam logic [HIST_W-1:0] H_RELEASE = 3'h4;
  localparam logic [HIST_W-1:0] H_GLITCH1 = 3'h5;
  localparam logic [HIST_W-1:0] H_DOWN    = 3'h7;

  // One classified sample: which keys emit, and each key's event code
  typedef struct packed {
    logic [SLOTS-1:0]        mask;
    logic [SLOTS*CODE_W-1:0] codes;
  } rec_t;

  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic              has;
    logic [CODE_W-1:0] ev;
  } hist_res_t;

  // Shift one sample into a history, cancel a lone glitch, classify
  function automatic hist_res_t hist_step(input logic [HIST_W-1:0] old_h,
                                          input logic pressed);
    hist_res_t r;
    r.hist = {old_h[HIST_W-2:0], pressed};
    r.has  = 1'b0;
    r.ev   = EV_UP;
    case (r.hist)
      H_UP:      begin r.has = 1'b1; r.ev = EV_UP;      end
      H_PUSH:    begin r.has = 1'b1; r.ev = EV_PUSH;    end
      H_RELEASE: begin r.has = 1'b1; r.ev = EV_RELEASE; end
      H_DOWN:    begin r.has = 1'b1; r.ev = EV_DOWN;    end
      H_GLITCH0: r.hist = H_UP;
      H_GLITCH1: r.hist = H_DOWN;
      default:   r.has = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mkde_front.sv
// Front end: configuration registers, key histories and sample classification.
`timescale 1ns / 1ps
`default_nettype none
module mkde_front
  import mkde_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   accept,
  input  wire logic [SLOTS-1:0]       key_levels,
  output rec_t                        rec,
  output logic                        rec_valid
);

  logic [SLOTS-1:0]        key_enable;
  logic [SLOTS-1:0]        press_polarity;
  logic [4*SLOTS-1:0]      event_enable;
  logic [HIST_W-1:0]       key_history [SLOTS];
  logic [HIST_W-1:0]       key_history_next [SLOTS];
  hist_res_t               res [SLOTS];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable     <= '0;
      press_polarity <= '0;
      event_enable   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_ENABLE:     key_enable     <= cfg_data[SLOTS-1:0];
        REG_PRESS_POLARITY: press_polarity <= cfg_data[SLOTS-1:0];
        REG_EVENT_ENABLE:   event_enable   <= cfg_data[4*SLOTS-1:0];
        default:            ;
      endcase
    end
  end

  // Classify every key in parallel; disabled slots keep their history
  always_comb begin
    rec = '0;
    for (int k = 0; k < SLOTS; k++) begin
      res[k] = hist_step(key_history[k], key_levels[k] == press_polarity[k]);
      key_history_next[k] = key_history[k];
      if (k < NUM_KEYS && key_enable[k]) begin
        key_history_next[k] = res[k].hist;
        rec.mask[k] = res[k].has && event_enable[4*k + int'(res[k].ev)];
        rec.codes[CODE_W*k +: CODE_W] = res[k].ev;
      end
    end
    rec_valid = accept && (rec.mask != '0);
  end

  // Advance histories on each accepted word
  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOTS; k++) begin
      if (rst) begin
        key_history[k] <= '0;
      end else if (accept) begin
        key_history[k] <= key_history_next[k];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/mkde_queue.sv
// Short queue of classified samples between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module mkde_queue
  import mkde_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire rec_t wr_data,
  input  wire logic rd_en,
  output rec_t      rd_data,
  output logic      full,
  output logic      empty
);

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end
  end

endmodule
`default_nettype wire

>>> rtl/mkde_back.sv
// Back end: drain one event per cycle, while the receiver pops, from a classified sample into the output word.
`timescale 1ns / 1ps
`default_nettype none
module mkde_back
  import mkde_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire rec_t              q_data,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [IDX_W-1:0]       key_index,
  output logic [CODE_W-1:0]      event_code,
  output logic                   last
);

  logic [SLOTS-1:0]        work_mask;
  logic [SLOTS*CODE_W-1:0] work_codes;
  logic [SLOTS-1:0]        work_mask_next;
  logic [SLOTS-1:0]        rest_mask;
  logic [IDX_W-1:0]        low_idx;
  logic                    out_valid;
  logic                    pop_ok;
  logic                    consume;

  // Find lowest pending key
  always_comb begin
    low_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (work_mask[k]) begin
        low_idx = IDX_W'(k);
      end
    end
  end

  assign pop_ok    = pop && out_valid;
  assign consume   = (work_mask != '0) && (!out_valid || pop_ok);
  assign rest_mask = work_mask & ~(SLOTS'(1) << low_idx);

  always_comb begin
    work_mask_next = consume ? rest_mask : work_mask;
    q_pop          = !q_empty && (work_mask_next == '0);
  end

  // Hold the sample being drained; reload from the queue when done
  always_ff @(posedge clk) begin
    if (rst) begin
      work_mask <= '0;
    end else if (q_pop) begin
      work_mask <= q_data.mask;
    end else begin
      work_mask <= work_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_codes <= q_data.codes;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume) begin
      out_valid <= 1'b1;
    end else if (pop_ok) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      key_index  <= low_idx;
      event_code <= work_codes[CODE_W*low_idx +: CODE_W];
      last       <= (rest_mask == '0);
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

>>> rtl/multi_key_debounce_events_core.sv
// Top level: three-sample debouncer for up to 16 keys with an event queue.
//
// Input side: present a scan sample on key_levels and raise push; the word
// is taken at a clock edge where push is high and full is low.
// Output side: while empty is low, key_index, event_code and last describe
// the oldest event; raise pop to take it. Events leave in key order, and last
// marks the final event of a sample. A sample that raises no enabled event
// produces no output word at all.
// Path: the first event of a sample passes from the sample queue through the
// back end's work register into the output register. The back end drains one
// event per cycle while the receiver pops, so a sample of 1 to 16 events uses
// output bandwidth in proportion to its events; the front end takes a
// sample every cycle while the two-entry sample queue has room. A stalled
// receiver fills that queue and then raises full.
// Configuration: cfg_valid/cfg_ready write key_enable (0), press_polarity (1)
// or event_enable (2); cfg_ready is always high. Write only while idle.
// Reset (rst, synchronous, active high) clears registers, all key histories,
// the queue and the output word.
`timescale 1ns / 1ps
`default_nettype none
module multi_key_debounce_events_core
  import mkde_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SLOTS-1:0]       key_levels,
  input  wire logic                   pop,
  output logic                        empty,
  output logic [IDX_W-1:0]            key_index,
  output logic [CODE_W-1:0]           event_code,
  output logic                        last
);

  rec_t rec;
  rec_t q_data;
  logic rec_valid;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  mkde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .key_levels (key_levels),
    .rec        (rec),
    .rec_valid  (rec_valid)
  );

  mkde_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_valid),
    .wr_data (rec),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  mkde_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .key_index  (key_index),
    .event_code (event_code),
    .last       (last)
  );

endmodule
`default_nettype wire
